[src/svsd_pkg.sv]
// ----------------------------------------------------------------------------
// Stream variance package
// Widths, result limits and shared types for the streaming mean, variance
// and standard deviation block.
// ----------------------------------------------------------------------------
package svsd_pkg;

    // Fixed configuration of the block.
    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 20;
    localparam int FRAC_BITS   = 8;

    // Result field widths.
    localparam int MEAN_W = 24;
    localparam int VAR_W  = 38;
    localparam int STD_W  = 23;

    // Accumulator widths: the count reaches 2^COUNT_BITS itself.
    localparam int CNT_W = COUNT_BITS + 1;
    localparam int SUM_W = SAMPLE_BITS + COUNT_BITS;
    localparam int SQ_W  = 2 * SAMPLE_BITS - 1 + COUNT_BITS;

    // Post-processing widths.
    localparam int D_W    = CNT_W + SQ_W - 1;
    localparam int NSQ_W  = 2 * CNT_W - 1;
    localparam int MNUM_W = SUM_W + FRAC_BITS + 1;
    localparam int VNUM_W = D_W + FRAC_BITS + 1;
    localparam int RAD_W  = ((D_W + 2 * FRAC_BITS + 1) / 2) * 2;
    localparam int ROOT_W = RAD_W / 2;
    localparam int ALU_W  = VNUM_W;
    localparam int REM_W  = (NSQ_W + 1 > ROOT_W + 3) ? NSQ_W + 1 : ROOT_W + 3;
    localparam int SR_W   = (RAD_W > VNUM_W) ? RAD_W : VNUM_W;
    localparam int ITER_W = $clog2(SR_W + 1);

    // Running totals after the current sample has been taken in.
    typedef struct packed {
        logic [CNT_W-1:0]        count;
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sumsq;
        logic                    ovf;
    } t_totals;

    // One finished result.
    typedef struct packed {
        logic signed [MEAN_W-1:0] mean_q8;
        logic [VAR_W-1:0]         variance_q8;
        logic [STD_W-1:0]         std_dev_q8;
        logic                     count_overflow;
    } t_result;

    // Sequencer status seen by the top level.
    typedef struct packed {
        logic idle;
        logic done;
    } t_core_status;

    // Request to the shared adder.
    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } t_alu_req;

    // Answer of the shared adder; carry set on subtract means a >= b.
    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             carry;
    } t_alu_res;

endpackage

[src/svsd_if.sv]
// ----------------------------------------------------------------------------
// Stream variance channels
// Sample request channel and result request channel, each with valid/ready.
// ----------------------------------------------------------------------------
interface svsd_in_if import svsd_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;

    modport source (output valid, sample, last, input ready);
    modport sink (input valid, sample, last, output ready);
endinterface

interface svsd_out_if import svsd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [MEAN_W-1:0] mean_q8;
    logic [VAR_W-1:0]         variance_q8;
    logic [STD_W-1:0]         std_dev_q8;
    logic                     count_overflow;

    modport source (output valid, mean_q8, variance_q8, std_dev_q8, count_overflow,
                    input ready);
    modport sink (input valid, mean_q8, variance_q8, std_dev_q8, count_overflow,
                  output ready);
endinterface

[src/stream_variance_std_dev_unit.sv]
// ----------------------------------------------------------------------------
// Streaming mean, variance and standard deviation unit
// Samples come in on i_smp, one per request, with last marking the end of a
// set. While the sequencer is idle, samples that do not close a set are taken
// in one per cycle and only update the running count, sum and sum of squares;
// they give no result. A request with last set closes the set: the totals are
// handed to the sequencer and the accumulators start over for the next set.
// The sequencer then runs every step on one shared adder: magnitude, mean
// division (45 steps), n*sumsq and sum^2 by shift and add (57 steps), n^2
// (21 steps), variance division (80 steps), square root (44 bit pairs) and
// the standard deviation division (44 steps). The result enters the output
// register when it is empty or being taken and then shows on o_res; i_smp
// is not ready until the sequencer is idle again.
// If o_res is stalled, the result waits in the output register; a further
// finished result waits in the sequencer and input stays blocked.
// Reset clears the running totals, the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
module stream_variance_std_dev_unit import svsd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    svsd_in_if.sink           i_smp,
    svsd_out_if.source        o_res
);

    t_totals      totals;
    t_core_status status;
    t_result      core_result;
    logic         accept;
    logic         start;
    logic         load;
    logic         r_out_valid;
    t_result      r_out;

    // Samples are taken while the sequencer is idle.
    assign i_smp.ready = status.idle;
    assign accept      = i_smp.valid & i_smp.ready;
    assign start       = accept & i_smp.last;

    svsd_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (accept),
        .i_sample (i_smp.sample),
        .i_last   (i_smp.last),
        .o_totals (totals)
    );

    svsd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_totals (totals),
        .i_taken  (load),
        .o_status (status),
        .o_result (core_result)
    );

    // Output register: refilled once the previous result request is taken.
    assign load = status.done & (~r_out_valid | o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= core_result;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.mean_q8        = r_out.mean_q8;
    assign o_res.variance_q8    = r_out.variance_q8;
    assign o_res.std_dev_q8     = r_out.std_dev_q8;
    assign o_res.count_overflow = r_out.count_overflow;

endmodule

[src/svsd_alu.sv]
// ----------------------------------------------------------------------------
// Stream variance shared adder
// One wide add/subtract unit with carry out, reused by every post-processing
// step: magnitude, rounding offsets, shift-add products, division and root.
// ----------------------------------------------------------------------------
module svsd_alu import svsd_pkg::*; (
    input  t_alu_req i_req,
    output t_alu_res o_res
);

    logic [ALU_W-1:0] b_eff;
    logic [ALU_W:0]   total;

    // Subtract is add of the inverted operand plus one.
    assign b_eff = i_req.sub ? ~i_req.b : i_req.b;
    assign total = {1'b0, i_req.a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, i_req.sub};

    assign o_res.sum   = total[ALU_W-1:0];
    assign o_res.carry = total[ALU_W];

endmodule

[src/svsd_accum.sv]
// ----------------------------------------------------------------------------
// Stream variance accumulator
// Keeps the sample count, sum and sum of squares of the open set, saturates
// the count at its limit and clears everything after the last sample.
// ----------------------------------------------------------------------------
module svsd_accum import svsd_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_last,
    output t_totals                       o_totals
);

    logic [CNT_W-1:0]              r_count;
    logic signed [SUM_W-1:0]       r_sum;
    logic [SQ_W-1:0]               r_sumsq;
    logic                          r_ovf;
    logic                          at_limit;
    logic signed [2*SAMPLE_BITS-1:0] square;
    t_totals                       n_totals;

    // The count never passes the limit, so its top bit marks a full set.
    assign at_limit = r_count[CNT_W-1];
    assign square   = i_sample * i_sample;

    // Totals including the offered sample; a sample past the limit is dropped.
    always_comb begin
        if (at_limit) begin
            n_totals.count = r_count;
            n_totals.sum   = r_sum;
            n_totals.sumsq = r_sumsq;
        end else begin
            n_totals.count = r_count + CNT_W'(1);
            n_totals.sum   = r_sum + SUM_W'(i_sample);
            n_totals.sumsq = r_sumsq + SQ_W'(square[2*SAMPLE_BITS-2:0]);
        end
        n_totals.ovf = r_ovf | at_limit;
    end

    assign o_totals = n_totals;

    // Update on every accepted sample and start over after the last one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
            r_ovf   <= 1'b0;
        end else if (i_take) begin
            if (i_last) begin
                r_count <= '0;
                r_sum   <= '0;
                r_sumsq <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_count <= n_totals.count;
                r_sum   <= n_totals.sum;
                r_sumsq <= n_totals.sumsq;
                r_ovf   <= n_totals.ovf;
            end
        end
    end

endmodule

[src/svsd_core.sv]
// ----------------------------------------------------------------------------
// Stream variance sequencer
// Works out mean, variance and standard deviation of one closed set with the
// shared adder: shift-add products, restoring division and a bit-pair root.
// ----------------------------------------------------------------------------
module svsd_core import svsd_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  t_totals      i_totals,
    input  logic         i_taken,
    output t_core_status o_status,
    output t_result      o_result
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_ABS   = 12'b0000_0000_0010,
        S_MPREP = 12'b0000_0000_0100,
        S_MDIV  = 12'b0000_0000_1000,
        S_DMUL  = 12'b0000_0001_0000,
        S_DSQ   = 12'b0000_0010_0000,
        S_NSQ   = 12'b0000_0100_0000,
        S_VPREP = 12'b0000_1000_0000,
        S_VDIV  = 12'b0001_0000_0000,
        S_SQRT  = 12'b0010_0000_0000,
        S_SDIV  = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    logic [ITER_W-1:0]        r_cnt;
    logic [CNT_W-1:0]         r_n;
    logic [SUM_W-1:0]         r_mag;
    logic                     r_neg;
    logic [SQ_W-1:0]          r_sumsq;
    logic                     r_ovf;
    logic [ALU_W-1:0]         r_acc;
    logic [ALU_W-1:0]         r_opd;
    logic [SUM_W-1:0]         r_mul;
    logic [D_W-1:0]           r_d;
    logic [NSQ_W-1:0]         r_nsq;
    logic [SR_W-1:0]          r_dvd;
    logic [REM_W-1:0]         r_rem;
    logic [ROOT_W-1:0]        r_root;
    logic signed [MEAN_W-1:0] r_mean;
    logic [VAR_W-1:0]         r_var;
    logic [STD_W-1:0]         r_std;

    t_alu_req          alu_req;
    t_alu_res          alu_res;
    logic              last_iter;
    logic [REM_W-1:0]  div_trial;
    logic [ALU_W-1:0]  divisor;
    logic [SR_W-1:0]   div_q;
    logic [REM_W-1:0]  sq_trial;
    logic [ROOT_W+1:0] sq_test;
    logic [ROOT_W-1:0] root_next;
    logic [MEAN_W-1:0] mean_sat;
    logic [VAR_W-1:0]  var_sat;
    logic [STD_W-1:0]  std_sat;

    svsd_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    assign last_iter = (r_cnt == ITER_W'(1));

    // Division step: bring down the next dividend bit and try the divisor.
    assign div_trial = {r_rem[REM_W-2:0], r_dvd[SR_W-1]};
    assign divisor   = (r_state == S_VDIV) ? ALU_W'(r_nsq) : ALU_W'(r_n);
    assign div_q     = {r_dvd[SR_W-2:0], alu_res.carry};

    // Root step: bring down two radicand bits and try 4*root + 1.
    assign sq_trial  = {r_rem[REM_W-3:0], r_dvd[SR_W-1 -: 2]};
    assign sq_test   = {r_root, 2'b01};
    assign root_next = {r_root[ROOT_W-2:0], alu_res.carry};

    // Saturation of the finished quotients.
    always_comb begin
        if (r_neg) begin
            if ((|div_q[SR_W-1:MEAN_W]) || (div_q[MEAN_W-1] && (|div_q[MEAN_W-2:0]))) begin
                mean_sat = {1'b1, {(MEAN_W-1){1'b0}}};
            end else begin
                mean_sat = MEAN_W'(0) - div_q[MEAN_W-1:0];
            end
        end else begin
            if (|div_q[SR_W-1:MEAN_W-1]) begin
                mean_sat = {1'b0, {(MEAN_W-1){1'b1}}};
            end else begin
                mean_sat = div_q[MEAN_W-1:0];
            end
        end
        var_sat = (|div_q[SR_W-1:VAR_W]) ? {VAR_W{1'b1}} : div_q[VAR_W-1:0];
        std_sat = (|div_q[SR_W-1:STD_W]) ? {STD_W{1'b1}} : div_q[STD_W-1:0];
    end

    // Operand selection for the shared adder.
    always_comb begin
        alu_req.a   = '0;
        alu_req.b   = '0;
        alu_req.sub = 1'b0;
        case (r_state)
            S_ABS: begin
                alu_req.a   = r_neg ? '0 : ALU_W'(r_mag);
                alu_req.b   = r_neg ? ALU_W'(r_mag) : '0;
                alu_req.sub = r_neg;
            end
            S_MPREP: begin
                alu_req.a = ALU_W'(r_mag) << FRAC_BITS;
                alu_req.b = ALU_W'(r_n >> 1);
            end
            S_VPREP: begin
                alu_req.a = ALU_W'(r_d) << FRAC_BITS;
                alu_req.b = ALU_W'(r_nsq >> 1);
            end
            S_MDIV, S_VDIV, S_SDIV: begin
                alu_req.a   = ALU_W'(div_trial);
                alu_req.b   = divisor;
                alu_req.sub = 1'b1;
            end
            S_DMUL, S_NSQ: begin
                alu_req.a = r_acc;
                alu_req.b = r_mul[0] ? r_opd : '0;
            end
            S_DSQ: begin
                alu_req.a   = r_acc;
                alu_req.b   = r_mul[0] ? r_opd : '0;
                alu_req.sub = 1'b1;
            end
            S_SQRT: begin
                alu_req.a   = ALU_W'(sq_trial);
                alu_req.b   = ALU_W'(sq_test);
                alu_req.sub = 1'b1;
            end
            default: begin
                alu_req.a   = '0;
                alu_req.b   = '0;
                alu_req.sub = 1'b0;
            end
        endcase
    end

    // Step sequence.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_start) n_state = S_ABS;
            S_ABS:   n_state = S_MPREP;
            S_MPREP: n_state = S_MDIV;
            S_MDIV:  if (last_iter) n_state = S_DMUL;
            S_DMUL:  if (last_iter) n_state = S_DSQ;
            S_DSQ:   if (last_iter) n_state = S_NSQ;
            S_NSQ:   if (last_iter) n_state = S_VPREP;
            S_VPREP: n_state = S_VDIV;
            S_VDIV:  if (last_iter) n_state = S_SQRT;
            S_SQRT:  if (last_iter) n_state = S_SDIV;
            S_SDIV:  if (last_iter) n_state = S_DONE;
            S_DONE:  if (i_taken) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers, loaded and shifted per step.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_n     <= i_totals.count;
                    r_mag   <= i_totals.sum;
                    r_neg   <= i_totals.sum[SUM_W-1];
                    r_sumsq <= i_totals.sumsq;
                    r_ovf   <= i_totals.ovf;
                end
            end
            S_ABS: begin
                r_mag <= alu_res.sum[SUM_W-1:0];
            end
            S_MPREP: begin
                r_dvd <= SR_W'(alu_res.sum[MNUM_W-1:0]) << (SR_W - MNUM_W);
                r_rem <= '0;
                r_cnt <= ITER_W'(MNUM_W);
            end
            S_MDIV, S_VDIV, S_SDIV: begin
                r_rem <= alu_res.carry ? alu_res.sum[REM_W-1:0] : div_trial;
                r_dvd <= div_q;
                r_cnt <= r_cnt - ITER_W'(1);
                if (last_iter) begin
                    if (r_state == S_MDIV) begin
                        r_mean <= mean_sat;
                        r_acc  <= '0;
                        r_opd  <= ALU_W'(r_sumsq);
                        r_mul  <= SUM_W'(r_n);
                        r_cnt  <= ITER_W'(CNT_W);
                    end else if (r_state == S_VDIV) begin
                        r_var  <= var_sat;
                        r_dvd  <= SR_W'(r_d) << (2 * FRAC_BITS + SR_W - RAD_W);
                        r_rem  <= '0;
                        r_root <= '0;
                        r_cnt  <= ITER_W'(ROOT_W);
                    end else begin
                        r_std <= std_sat;
                    end
                end
            end
            S_DMUL, S_DSQ, S_NSQ: begin
                r_acc <= alu_res.sum;
                r_opd <= r_opd << 1;
                r_mul <= r_mul >> 1;
                r_cnt <= r_cnt - ITER_W'(1);
                if (last_iter) begin
                    if (r_state == S_DMUL) begin
                        r_opd <= ALU_W'(r_mag);
                        r_mul <= r_mag;
                        r_cnt <= ITER_W'(SUM_W);
                    end else if (r_state == S_DSQ) begin
                        r_d   <= alu_res.sum[D_W-1:0];
                        r_acc <= '0;
                        r_opd <= ALU_W'(r_n);
                        r_mul <= SUM_W'(r_n);
                        r_cnt <= ITER_W'(CNT_W);
                    end else begin
                        r_nsq <= alu_res.sum[NSQ_W-1:0];
                    end
                end
            end
            S_VPREP: begin
                r_dvd <= SR_W'(alu_res.sum[VNUM_W-1:0]) << (SR_W - VNUM_W);
                r_rem <= '0;
                r_cnt <= ITER_W'(VNUM_W);
            end
            S_SQRT: begin
                r_root <= root_next;
                r_cnt  <= r_cnt - ITER_W'(1);
                if (last_iter) begin
                    r_dvd <= SR_W'(root_next) << (SR_W - ROOT_W);
                    r_rem <= '0;
                    r_cnt <= ITER_W'(ROOT_W);
                end else begin
                    r_dvd <= r_dvd << 2;
                    r_rem <= alu_res.carry ? alu_res.sum[REM_W-1:0] : sq_trial;
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    assign o_status.idle = (r_state == S_IDLE);
    assign o_status.done = (r_state == S_DONE);

    assign o_result.mean_q8        = r_mean;
    assign o_result.variance_q8    = r_var;
    assign o_result.std_dev_q8     = r_std;
    assign o_result.count_overflow = r_ovf;

endmodule
